// ----- rtl/core/wbs_pkg.sv -----
// shared types, character classes and the pair rule for the word break segmenter
package wbs_pkg;

    localparam int unsigned MAX_TEXT_LEN_DEF = 65536;

    typedef logic [15:0] char_t;
    typedef logic [15:0] offset_t;
    typedef logic [16:0] length_t;

    typedef struct packed {
        offset_t word_offset;
        length_t word_length;
        logic    last_word;
    } word_t;

    localparam char_t CHAR_CR    = 16'h000D;
    localparam char_t CHAR_LF    = 16'h000A;
    localparam char_t ASCII_MAX  = 16'h007F;
    localparam char_t DIGIT_ZERO = 16'h0030;
    localparam char_t DIGIT_NINE = 16'h0039;

    function automatic logic is_brk_forced(input char_t c);
        return c inside {16'h0020, 16'h0009, 16'h000D, 16'h000A, 16'h3000,
                         16'h0040, 16'h002A, 16'h007C, 16'h002F};
    endfunction

    function automatic logic is_lnk_next(input char_t c);
        return c inside {16'h0028, 16'h005B, 16'h007B, 16'h0022, 16'h0027, 16'h003C,
                         16'h2018, 16'h201C, 16'hFF08, 16'h3014, 16'hFF3B, 16'hFF5B,
                         16'h3008, 16'h300A, 16'h300C, 16'h300E, 16'h3010};
    endfunction

    function automatic logic is_lnk_prev(input char_t c);
        return c inside {16'h002C, 16'h002E, 16'h003B, 16'h003A, 16'h0029, 16'h005D,
                         16'h007D, 16'h0022, 16'h0027, 16'h003E,
                         16'h3001, 16'h3002, 16'hFF0C, 16'hFF0E, 16'h2019, 16'h201D,
                         16'hFF09, 16'h3015, 16'hFF3D, 16'hFF5D, 16'h3009, 16'h300B,
                         16'h300D, 16'h300F, 16'h3011};
    endfunction

    function automatic logic is_no_begin(input char_t c);
        return c inside {16'h30FB, 16'hFF1A, 16'hFF1B, 16'hFF1F, 16'hFF01, 16'h30FD,
                         16'h30FE, 16'h309D, 16'h309E, 16'h3003, 16'h3005, 16'h30FC,
                         16'h2015, 16'hFF5E, 16'h2026, 16'h2025,
                         16'h3063, 16'h3083, 16'h3085, 16'h3087, 16'h30C3, 16'h30E3,
                         16'h30E5, 16'h30E7, 16'h3041, 16'h3043, 16'h3045, 16'h3047,
                         16'h3049, 16'h30A1, 16'h30A3, 16'h30A5, 16'h30A7, 16'h30A9};
    endfunction

    function automatic logic is_brk_after(input char_t c);
        return c inside {16'h0029, 16'h005D, 16'h007D, 16'h003B, 16'h003E,
                         16'h0021, 16'h0025, 16'h0026, 16'h003F};
    endfunction

    function automatic logic is_num_link(input char_t c);
        return c inside {16'h002E, 16'h002C, 16'h002D, 16'h003A, 16'h0024, 16'h005C};
    endfunction

    function automatic logic is_brk_before(input char_t c);
        return c inside {16'h0028, 16'h005B, 16'h007B, 16'h003C};
    endfunction

    // first matching rule wins
    function automatic logic pair_joins(input char_t p, input char_t c);
        logic joins;
        if (p == CHAR_CR && c == CHAR_LF)
            joins = 1'b1;
        else if (is_brk_forced(p) || is_brk_forced(c))
            joins = 1'b0;
        else if (is_lnk_next(p) || is_lnk_prev(c))
            joins = 1'b1;
        else if (p <= ASCII_MAX)
        begin
            if (is_brk_after(p) || is_brk_before(c))
                joins = 1'b0;
            else if (is_num_link(p))
                joins = (c >= DIGIT_ZERO) && (c <= DIGIT_NINE);
            else
                joins = (c <= ASCII_MAX);
        end
        else
            joins = is_no_begin(c);
        return joins;
    endfunction

endpackage

// ----- rtl/core/wbs_char_if.sv -----
// character channel: valid/ready handshake with one text character per transfer
interface wbs_char_if;
    logic            valid;
    logic            ready;
    wbs_pkg::char_t  char_code;
    logic            end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

// ----- rtl/core/wbs_word_if.sv -----
// result channel: valid/ready handshake with one segmented word per transfer
interface wbs_word_if;
    logic              valid;
    logic              ready;
    wbs_pkg::offset_t  word_offset;
    wbs_pkg::length_t  word_length;
    logic              last_word;

    modport source (output valid, output word_offset, output word_length,
                    output last_word, input ready);
    modport sink   (input valid, input word_offset, input word_length,
                    input last_word, output ready);
endinterface

// ----- rtl/core/word_break_segmenter.sv -----
// word break segmenter: splits a character stream into unbreakable words
// Takes one character per cycle on chars and returns the words found on words, each as
// offset and length within the text, with last_word set on the final word of a text.
// A character first lands in an input register; from there, once the queue has room for
// two words, the pair rule and the word counters update and write zero, one or two words
// into a four-entry result queue. A character is taken every cycle as long as the queue
// has room for two words, so the rate is one character per cycle while at most one word
// per character comes out; it is bound by the single read port of the result queue, one
// word per cycle. Lengths saturate at MAX_TEXT_LEN and offsets at MAX_TEXT_LEN - 1.
// There is no clearing pass after reset.
module word_break_segmenter #(
    parameter int unsigned MAX_TEXT_LEN = wbs_pkg::MAX_TEXT_LEN_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    wbs_char_if.sink      chars,
    wbs_word_if.source    words
);
    import wbs_pkg::*;

    localparam logic [17:0] MaxLen  = 18'(MAX_TEXT_LEN);
    localparam logic [17:0] MaxOff  = 18'(MAX_TEXT_LEN - 1);
    localparam int          QDepth  = 4;
    localparam int          QPtrW   = $clog2(QDepth);
    localparam int          QCntW   = $clog2(QDepth + 1);

    // input register
    logic     in_valid_reg;
    char_t    in_char_reg;
    logic     in_eot_reg;

    // segmentation state
    char_t    prev_char_reg;
    logic     inside_reg;
    offset_t  start_reg;
    length_t  count_reg;
    offset_t  start_next;
    length_t  count_next;

    // result queue
    word_t               q_mem [QDepth];
    logic [QPtrW-1:0]    wr_ptr_reg;
    logic [QPtrW-1:0]    rd_ptr_reg;
    logic [QCntW-1:0]    q_cnt_reg;

    logic        step_fire;
    logic        in_fire;
    logic        pop;
    logic        joins;
    logic        brk;
    logic        push0;
    logic        push1;
    logic [17:0] sum;
    word_t       word0;
    word_t       word1;
    word_t       head;

    assign step_fire   = in_valid_reg && (q_cnt_reg <= QCntW'(QDepth - 2));
    assign chars.ready = !in_valid_reg || step_fire;
    assign in_fire     = chars.valid && chars.ready;
    assign pop         = words.valid && words.ready;

    assign head              = q_mem[rd_ptr_reg];
    assign words.valid       = (q_cnt_reg != '0);
    assign words.word_offset = head.word_offset;
    assign words.word_length = head.word_length;
    assign words.last_word   = head.last_word;

    always_comb
    begin
        joins      = pair_joins(prev_char_reg, in_char_reg);
        brk        = inside_reg && !joins;
        sum        = {2'b00, start_reg} + {1'b0, count_reg};
        start_next = start_reg;
        count_next = count_reg;
        if (!inside_reg)
        begin
            start_next = '0;
            count_next = length_t'(1);
        end
        else if (joins)
        begin
            if ({1'b0, count_reg} < MaxLen)
                count_next = count_reg + length_t'(1);
        end
        else
        begin
            start_next = (sum > MaxOff) ? MaxOff[15:0] : sum[15:0];
            count_next = length_t'(1);
        end
        // on a break the finished word goes first, the final word second
        word0 = brk ? word_t'{word_offset: start_reg, word_length: count_reg,
                              last_word: 1'b0}
                    : word_t'{word_offset: start_next, word_length: count_next,
                              last_word: 1'b1};
        word1 = '{word_offset: start_next, word_length: count_next, last_word: 1'b1};
        push0 = step_fire && (brk || in_eot_reg);
        push1 = step_fire && brk && in_eot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step_fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_char_reg <= chars.char_code;
            in_eot_reg  <= chars.end_of_text;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_char_reg <= '0;
            inside_reg    <= 1'b0;
            start_reg     <= '0;
            count_reg     <= '0;
        end
        else if (step_fire)
        begin
            prev_char_reg <= in_char_reg;
            inside_reg    <= !in_eot_reg;
            start_reg     <= start_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0)
            q_mem[wr_ptr_reg] <= word0;
        if (push1)
            q_mem[wr_ptr_reg + QPtrW'(1)] <= word1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QPtrW'(push0) + QPtrW'(push1);
            rd_ptr_reg <= rd_ptr_reg + QPtrW'(pop);
            q_cnt_reg  <= q_cnt_reg + QCntW'(push0) + QCntW'(push1) - QCntW'(pop);
        end
    end

endmodule

// ----- rtl/core/wbs_checker.sv -----
// port-level checks for the word break segmenter, bound to every word_break_segmenter instance
module wbs_checker #(
    parameter int unsigned MAX_TEXT_LEN = wbs_pkg::MAX_TEXT_LEN_DEF
) (
    input logic             clk,
    input logic             rst_n,
    input logic             chars_valid,
    input logic             chars_ready,
    input logic             words_valid,
    input logic             words_ready,
    input wbs_pkg::offset_t word_offset,
    input wbs_pkg::length_t word_length,
    input logic             last_word
);
    import wbs_pkg::*;

    localparam logic [17:0] MaxLen = 18'(MAX_TEXT_LEN);

    // set once any character has been taken since reset
    logic seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= 1'b0;
        else if (chars_valid && chars_ready)
            seen_reg <= 1'b1;
    end

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        words_valid && !words_ready |=> words_valid)
        else $error("word dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        words_valid && !words_ready |=>
            $stable(word_offset) && $stable(word_length) && $stable(last_word))
        else $error("word changed while stalled");

    a_length_range: assert property (@(posedge clk) disable iff (!rst_n)
        words_valid |-> (word_length != '0) && ({1'b0, word_length} <= MaxLen))
        else $error("word length out of range");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        words_valid |-> seen_reg)
        else $error("word shown before any character was taken");

endmodule

bind word_break_segmenter wbs_checker #(
    .MAX_TEXT_LEN (MAX_TEXT_LEN)
) u_wbs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .chars_valid (chars.valid),
    .chars_ready (chars.ready),
    .words_valid (words.valid),
    .words_ready (words.ready),
    .word_offset (words.word_offset),
    .word_length (words.word_length),
    .last_word   (words.last_word)
);

// ----- tb/word_break_checker.sv -----
// checker for the word break segmenter: predicts the words of each text and compares them
`timescale 1ns / 1ps

module word_break_checker #(
    parameter int unsigned MAX_LEN = wbs_pkg::MAX_TEXT_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    wbs_char_if         chars,
    wbs_word_if         words,
    output int unsigned fail_count,
    output int unsigned pending,
    output int unsigned chars_seen
);

    import wbs_pkg::*;

    word_t       predicted_words[$];
    word_t       want;
    char_t       last_char;
    logic        in_text;
    offset_t     cur_start;
    length_t     cur_len;
    int unsigned errors;
    int unsigned seen;

    function automatic logic hard_break(input char_t c);
        logic hit;
        case (c)
            16'h0020, 16'h0009, 16'h000D, 16'h000A, 16'h3000,
            16'h0040, 16'h002A, 16'h007C, 16'h002F:
                hit = 1'b1;
            default:
                hit = 1'b0;
        endcase
        return hit;
    endfunction

    // openers that cling to the following character
    function automatic logic glues_forward(input char_t c);
        logic hit;
        case (c)
            16'h0028, 16'h005B, 16'h007B, 16'h0022, 16'h0027, 16'h003C,
            16'h2018, 16'h201C, 16'hFF08, 16'h3014, 16'hFF3B, 16'hFF5B,
            16'h3008, 16'h300A, 16'h300C, 16'h300E, 16'h3010:
                hit = 1'b1;
            default:
                hit = 1'b0;
        endcase
        return hit;
    endfunction

    // closers and punctuation that cling to the preceding character
    function automatic logic glues_backward(input char_t c);
        logic hit;
        case (c)
            16'h002C, 16'h002E, 16'h003B, 16'h003A, 16'h0029, 16'h005D,
            16'h007D, 16'h0022, 16'h0027, 16'h003E,
            16'h3001, 16'h3002, 16'hFF0C, 16'hFF0E, 16'h2019, 16'h201D,
            16'hFF09, 16'h3015, 16'hFF3D, 16'hFF5D, 16'h3009, 16'h300B,
            16'h300D, 16'h300F, 16'h3011:
                hit = 1'b1;
            default:
                hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic cannot_start(input char_t c);
        logic hit;
        case (c)
            16'h30FB, 16'hFF1A, 16'hFF1B, 16'hFF1F, 16'hFF01, 16'h30FD,
            16'h30FE, 16'h309D, 16'h309E, 16'h3003, 16'h3005, 16'h30FC,
            16'h2015, 16'hFF5E, 16'h2026, 16'h2025,
            16'h3063, 16'h3083, 16'h3085, 16'h3087, 16'h30C3, 16'h30E3,
            16'h30E5, 16'h30E7, 16'h3041, 16'h3043, 16'h3045, 16'h3047,
            16'h3049, 16'h30A1, 16'h30A3, 16'h30A5, 16'h30A7, 16'h30A9:
                hit = 1'b1;
            default:
                hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic ends_ascii_word(input char_t c);
        logic hit;
        case (c)
            16'h0029, 16'h005D, 16'h007D, 16'h003B, 16'h003E,
            16'h0021, 16'h0025, 16'h0026, 16'h003F:
                hit = 1'b1;
            default:
                hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic starts_ascii_word(input char_t c);
        logic hit;
        case (c)
            16'h0028, 16'h005B, 16'h007B, 16'h003C:
                hit = 1'b1;
            default:
                hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic numeric_joiner(input char_t c);
        logic hit;
        case (c)
            16'h002E, 16'h002C, 16'h002D, 16'h003A, 16'h0024, 16'h005C:
                hit = 1'b1;
            default:
                hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic chars_stay_joined(input char_t p, input char_t c);
        logic ok;
        if (p == CHAR_CR && c == CHAR_LF)
            ok = 1'b1;
        else if (hard_break(p) || hard_break(c))
            ok = 1'b0;
        else if (glues_forward(p) || glues_backward(c))
            ok = 1'b1;
        else if (p <= ASCII_MAX)
        begin
            if (ends_ascii_word(p) || starts_ascii_word(c))
                ok = 1'b0;
            else if (numeric_joiner(p))
                ok = (c >= DIGIT_ZERO) && (c <= DIGIT_NINE);
            else
                ok = (c <= ASCII_MAX);
        end
        else
            ok = cannot_start(c);
        return ok;
    endfunction

    task automatic push_word(input offset_t off, input length_t len, input logic last);
        word_t w;
        w.word_offset = off;
        w.word_length = len;
        w.last_word   = last;
        predicted_words = {predicted_words, w};
    endtask

    task automatic segment_char(input char_t c, input logic eot);
        int unsigned next_start;
        if (!in_text)
        begin
            cur_start = '0;
            cur_len   = length_t'(1);
        end
        else if (chars_stay_joined(last_char, c))
        begin
            if (32'(cur_len) < MAX_LEN)
                cur_len = cur_len + length_t'(1);
        end
        else
        begin
            push_word(cur_start, cur_len, 1'b0);
            next_start = 32'(cur_start) + 32'(cur_len);
            if (next_start > MAX_LEN - 1)
                next_start = MAX_LEN - 1;
            cur_start = offset_t'(next_start);
            cur_len   = length_t'(1);
        end
        last_char = c;
        if (eot)
        begin
            push_word(cur_start, cur_len, 1'b1);
            in_text = 1'b0;
        end
        else
            in_text = 1'b1;
    endtask

    task automatic report_mismatch(input string what);
        errors++;
        $display("%0t ps: word check failed: %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            predicted_words.delete();
            last_char  = '0;
            in_text    = 1'b0;
            cur_start  = '0;
            cur_len    = '0;
            errors     = 0;
            seen       = 0;
            fail_count <= 0;
            pending    <= 0;
            chars_seen <= 0;
        end
        else
        begin
            if (words.valid && words.ready)
            begin
                if (predicted_words.size() == 0)
                    report_mismatch($sformatf("unexpected word offset %0d length %0d last %0b",
                                              words.word_offset, words.word_length,
                                              words.last_word));
                else
                begin
                    want = predicted_words.pop_front();
                    if (words.word_offset !== want.word_offset ||
                        words.word_length !== want.word_length ||
                        words.last_word !== want.last_word)
                        report_mismatch($sformatf(
                            "got offset %0d length %0d last %0b, want %0d %0d %0b",
                            words.word_offset, words.word_length, words.last_word,
                            want.word_offset, want.word_length, want.last_word));
                end
            end
            if (chars.valid && chars.ready)
            begin
                segment_char(chars.char_code, chars.end_of_text);
                seen++;
            end
            fail_count <= errors;
            pending    <= predicted_words.size();
            chars_seen <= seen;
        end
    end

endmodule

// ----- tb/word_break_segmenter_test.sv -----
// top of the word break segmenter testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module word_break_segmenter_test;

    import wbs_pkg::*;

    localparam int unsigned TEXT_LEN      = MAX_TEXT_LEN_DEF;
    localparam int unsigned RANDOM_ITEMS  = 800;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned DRAIN_CYCLES  = 16;
    localparam int unsigned LONG_HOLD_AT  = 400;
    localparam int unsigned LONG_HOLD_LEN = 600;

    logic        clk;
    logic        rst_n = 1'b0;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned chars_seen;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;
    logic        no_gaps = 1'b0;

    // every character that belongs to some class
    char_t char_pool [0:89] = '{
        16'h0020, 16'h0009, 16'h000D, 16'h000A, 16'h0040, 16'h002A, 16'h007C, 16'h002F,
        16'h0028, 16'h005B,
        16'h007B, 16'h0022, 16'h0027, 16'h003C, 16'h002C, 16'h002E, 16'h003B, 16'h003A,
        16'h0029, 16'h005D,
        16'h007D, 16'h003E, 16'h0021, 16'h0025, 16'h0026, 16'h003F, 16'h002D, 16'h0024,
        16'h005C, 16'h3000,
        16'h2018, 16'h201C, 16'hFF08, 16'h3014, 16'hFF3B, 16'hFF5B, 16'h3008, 16'h300A,
        16'h300C, 16'h300E,
        16'h3010, 16'h3001, 16'h3002, 16'hFF0C, 16'hFF0E, 16'h2019, 16'h201D, 16'hFF09,
        16'h3015, 16'hFF3D,
        16'hFF5D, 16'h3009, 16'h300B, 16'h300D, 16'h300F, 16'h3011, 16'h30FB, 16'hFF1A,
        16'hFF1B, 16'hFF1F,
        16'hFF01, 16'h30FD, 16'h30FE, 16'h309D, 16'h309E, 16'h3003, 16'h3005, 16'h30FC,
        16'h2015, 16'hFF5E,
        16'h2026, 16'h2025, 16'h3063, 16'h3083, 16'h3085, 16'h3087, 16'h30C3, 16'h30E3,
        16'h30E5, 16'h30E7,
        16'h3041, 16'h3043, 16'h3045, 16'h3047, 16'h3049, 16'h30A1, 16'h30A3, 16'h30A5,
        16'h30A7, 16'h30A9
    };

    wbs_char_if char_bus ();
    wbs_word_if word_bus ();

    word_break_segmenter #(
        .MAX_TEXT_LEN (TEXT_LEN)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (char_bus),
        .words (word_bus)
    );

    word_break_checker #(
        .MAX_LEN (TEXT_LEN)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (char_bus),
        .words      (word_bus),
        .fail_count (fail_count),
        .pending    (pending),
        .chars_seen (chars_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic char_t pick_char();
        int unsigned r;
        char_t c;
        r = $urandom_range(0, 99);
        if (r < 20)
            c = 16'($urandom_range(0, 1) ? 16'h0061 : 16'h0041) + 16'($urandom_range(0, 25));
        else if (r < 30)
            c = DIGIT_ZERO + 16'($urandom_range(0, 9));
        else if (r < 55)
            c = char_pool[$urandom_range(0, 89)];
        else if (r < 65)
            c = 16'h4E00 + 16'($urandom_range(0, 16'h51FF));
        else if (r < 72)
            c = 16'h3040 + 16'($urandom_range(0, 16'h00BF));
        else if (r < 82)
            c = 16'($urandom_range(0, 16'h007F));
        else if (r < 95)
            c = 16'($urandom_range(0, 16'hFFFF));
        else
        begin
            case ($urandom_range(0, 3))
                0: c = 16'h0000;
                1: c = 16'hFFFF;
                2: c = 16'h007F;
                default: c = 16'h0080;
            endcase
        end
        return c;
    endfunction

    task automatic send_char(input char_t c, input logic eot);
        int unsigned gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            char_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_bus.valid       <= 1'b1;
        char_bus.char_code   <= c;
        char_bus.end_of_text <= eot;
        @(posedge clk);
        while (!char_bus.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_text(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_char(pick_char(), i == len - 1);
    endtask

    // result side: random stalls, calm stretches and one long hold-off while chars keep coming
    initial
    begin : word_receiver
        int unsigned rx_cycles;
        int unsigned hold_left;
        int unsigned mode_left;
        int unsigned r;
        logic        calm;
        logic        take;
        rx_cycles = 0;
        hold_left = 0;
        mode_left = 0;
        calm      = 1'b0;
        word_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rx_cycles++;
            if (rx_cycles == LONG_HOLD_AT)
                hold_left = LONG_HOLD_LEN;
            if (hold_left > 0)
            begin
                take = 1'b0;
                hold_left--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    calm      = ($urandom_range(0, 3) == 0);
                    mode_left = $urandom_range(16, 200);
                end
                mode_left--;
                r = $urandom_range(0, 99);
                if (calm || r < 65)
                    take = 1'b1;
                else
                begin
                    take      = 1'b0;
                    hold_left = (r < 97) ? $urandom_range(0, 3) : $urandom_range(20, 80);
                end
            end
            word_bus.ready <= take;
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("word_break_segmenter_test NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned base;
        char_bus.valid       <= 1'b0;
        char_bus.char_code   <= '0;
        char_bus.end_of_text <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // single-character texts at both ends of the code range
        send_char(16'h0000, 1'b1);
        send_char(16'hFFFF, 1'b1);
        // cr-lf stays one word
        send_char(CHAR_CR, 1'b0);
        send_char(CHAR_LF, 1'b1);
        // break on the last character gives two words
        send_char(16'h0061, 1'b0);
        send_char(16'h0020, 1'b1);
        // number links: "1.5.x"
        send_char(16'h0031, 1'b0);
        send_char(16'h002E, 1'b0);
        send_char(16'h0035, 1'b0);
        send_char(16'h002E, 1'b0);
        send_char(16'h0078, 1'b1);
        // break after '!', break before '(', '(' joins forward: "!a(b"
        send_char(16'h0021, 1'b0);
        send_char(16'h0061, 1'b0);
        send_char(16'h0028, 1'b0);
        send_char(16'h0062, 1'b1);
        // non-ascii: small kana joins back, ideograph breaks, full stop joins back
        send_char(16'h4E00, 1'b0);
        send_char(16'h3063, 1'b0);
        send_char(16'h4E8C, 1'b0);
        send_char(16'h3002, 1'b1);
        // ascii followed by non-ascii breaks
        send_char(16'h0061, 1'b0);
        send_char(16'h3042, 1'b1);
        // cjk opening bracket joins forward
        send_char(16'h300C, 1'b0);
        send_char(16'h4E00, 1'b1);

        base = items_sent;
        while (items_sent < base + RANDOM_ITEMS)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 80)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_text($urandom_range(13, 40));
                else
                    send_text($urandom_range(1, 12));
            end
            else
                send_char(pick_char(), $urandom_range(0, 2) == 0);
        end
        no_gaps = 1'b0;
        send_char(16'h002E, 1'b1);
        send_text(3);

        char_bus.valid <= 1'b0;
        while (chars_seen != items_sent || pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("word_break_segmenter_test OK");
        else
            $display("word_break_segmenter_test NOT OK");
        $finish;
    end

endmodule
